// ----- rtl/ejd_pkg.sv -----
// ----------------------------------------------------------------------------
// ejd_pkg
// Shared types, sizes and codes for the exclusive-type job dispatcher.
// ----------------------------------------------------------------------------
package ejd_pkg;

  // Sizes
  localparam int PENDING_DEPTH = 16;
  localparam int ACTIVE_DEPTH  = 16;
  localparam int ID_WIDTH      = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int TYPE_W     = 32;
  localparam int DONE_W     = 16;
  localparam int JOB_ID_W   = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int OP_W       = 2;

  localparam int PEND_IDX_W = $clog2(PENDING_DEPTH);
  localparam int PEND_CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int ACT_IDX_W  = $clog2(ACTIVE_DEPTH);
  localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Command codes on the request port
  localparam logic [CMD_W-1:0] CMD_SCHED = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DONE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // Internal operation classes
  localparam logic [OP_W-1:0] OP_SCHED = 2'd0;
  localparam logic [OP_W-1:0] OP_DISP  = 2'd1;
  localparam logic [OP_W-1:0] OP_DONE  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DISABLED   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NONE       = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_ACTIVE = 3'd4;

  // Request as seen on the input port
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TYPE_W-1:0] job_type;
    logic              exclusive;
    logic [DONE_W-1:0] done_id;
  } req_t;

  // Result as seen on the output port
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [JOB_ID_W-1:0] job_id;
    logic [TYPE_W-1:0]   out_type;
  } rsp_t;

  // Classified request held between front and back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TYPE_W-1:0] job_type;
    logic              exclusive;
    logic [DONE_W-1:0] done_id;
  } op_t;

  // One pending list entry: type plus exclusive flag
  typedef struct packed {
    logic              excl;
    logic [TYPE_W-1:0] jtype;
  } pend_type_t;

endpackage

// ----- rtl/ejd_front.sv -----
// ----------------------------------------------------------------------------
// ejd_front
// Accepts requests, classifies the command and holds them in a short queue
// in front of the execution engine.
// ----------------------------------------------------------------------------
module ejd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ejd_pkg::req_t req,
  output logic          q_valid,
  output ejd_pkg::op_t  q_data,
  input  logic          q_take
);

  ejd_pkg::op_t                  ent [ejd_pkg::QUEUE_DEPTH];
  logic [ejd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ejd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ejd_pkg::QCNT_W-1:0]    cnt;
  ejd_pkg::op_t                  cls;
  logic                          do_push;
  logic                          do_pop;

  // Classify the command
  always_comb begin
    cls.job_type  = req.job_type;
    cls.exclusive = req.exclusive;
    cls.done_id   = req.done_id;
    unique case (req.cmd)
      ejd_pkg::CMD_SCHED: cls.op = ejd_pkg::OP_SCHED;
      ejd_pkg::CMD_DISP:  cls.op = ejd_pkg::OP_DISP;
      ejd_pkg::CMD_DONE:  cls.op = ejd_pkg::OP_DONE;
      ejd_pkg::CMD_NOP:   cls.op = ejd_pkg::OP_NOP;
    endcase
  end

  assign full    = (cnt == ejd_pkg::QCNT_W'(ejd_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt != '0);
  assign q_data  = ent[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= cls;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ejd_pkg::QPTR_W'(ejd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ejd_pkg::QPTR_W'(ejd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ejd_back.sv -----
// ----------------------------------------------------------------------------
// ejd_back
// Execution engine: pending list, active table, ID counter and the result
// register. Dispatch scans the active table one entry per cycle against all
// pending entries in parallel, then picks a job and an active slot.
// ----------------------------------------------------------------------------
module ejd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ejd_pkg::op_t  q_data,
  output logic          q_take,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data,
  output logic          empty,
  input  logic          pop,
  output ejd_pkg::rsp_t rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PICK   = 3'd2;
  localparam logic [2:0] S_SLOT   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  localparam int PD = ejd_pkg::PENDING_DEPTH;
  localparam int AD = ejd_pkg::ACTIVE_DEPTH;

  // Control state
  logic [2:0]                      state;
  logic [2:0]                      state_next;
  logic                            enable;
  logic [ejd_pkg::PEND_CNT_W-1:0]  pend_count;
  logic [AD-1:0]                   act_valid;
  logic [ejd_pkg::ID_WIDTH-1:0]    next_id;
  logic                            out_valid;
  logic [ejd_pkg::ACT_IDX_W-1:0]   scan_idx;

  // Payload state
  ejd_pkg::op_t                    cur;
  logic [ejd_pkg::ID_WIDTH-1:0]    pend_ids   [PD];
  ejd_pkg::pend_type_t             pend_types [PD];
  logic [ejd_pkg::ID_WIDTH-1:0]    act_ids    [AD];
  logic [ejd_pkg::TYPE_W-1:0]      act_types  [AD];
  logic [PD-1:0]                   blocked;
  logic                            pick_found;
  logic [ejd_pkg::PEND_IDX_W-1:0]  pick_idx;
  logic [ejd_pkg::ID_WIDTH-1:0]    pick_id;
  logic [ejd_pkg::TYPE_W-1:0]      pick_type;
  logic                            slot_ok;
  logic [ejd_pkg::ACT_IDX_W-1:0]   slot_idx;
  ejd_pkg::rsp_t                   out_rsp;

  // Combinational helpers
  logic                            commit;
  logic                            pick_found_c;
  logic [ejd_pkg::PEND_IDX_W-1:0]  pick_idx_c;
  logic                            slot_ok_c;
  logic [ejd_pkg::ACT_IDX_W-1:0]   slot_idx_c;
  logic                            done_hit;
  logic [ejd_pkg::ACT_IDX_W-1:0]   done_idx;
  logic                            sched_ok;
  logic                            disp_ok;
  logic [ejd_pkg::ID_WIDTH-1:0]    id_inc;
  ejd_pkg::rsp_t                   res;

  assign cfg_ready = 1'b1;
  assign q_take    = (state == S_IDLE) && q_valid;
  assign commit    = (state == S_COMMIT) && (!out_valid || pop);
  assign empty     = !out_valid;
  assign rsp       = out_rsp;
  assign id_inc    = next_id + 1'b1;

  // First eligible pending job
  always_comb begin
    pick_found_c = 1'b0;
    pick_idx_c   = '0;
    for (int i = PD - 1; i >= 0; i--) begin
      if ((ejd_pkg::PEND_CNT_W'(i) < pend_count) &&
          (!pend_types[i].excl || !blocked[i])) begin
        pick_found_c = 1'b1;
        pick_idx_c   = ejd_pkg::PEND_IDX_W'(i);
      end
    end
  end

  // Active slot for the picked job: same ID first, else first free entry
  always_comb begin
    logic                          hit;
    logic [ejd_pkg::ACT_IDX_W-1:0] hit_idx;
    logic                          fre;
    logic [ejd_pkg::ACT_IDX_W-1:0] fre_idx;
    hit     = 1'b0;
    hit_idx = '0;
    fre     = 1'b0;
    fre_idx = '0;
    for (int j = AD - 1; j >= 0; j--) begin
      if (act_valid[j] && (act_ids[j] == pick_id)) begin
        hit     = 1'b1;
        hit_idx = ejd_pkg::ACT_IDX_W'(j);
      end
      if (!act_valid[j]) begin
        fre     = 1'b1;
        fre_idx = ejd_pkg::ACT_IDX_W'(j);
      end
    end
    slot_ok_c  = hit || fre;
    slot_idx_c = hit ? hit_idx : fre_idx;
  end

  // Lookup of a completed ID
  always_comb begin
    done_hit = 1'b0;
    done_idx = '0;
    for (int j = AD - 1; j >= 0; j--) begin
      if (act_valid[j] && (32'(act_ids[j]) == 32'(cur.done_id))) begin
        done_hit = 1'b1;
        done_idx = ejd_pkg::ACT_IDX_W'(j);
      end
    end
  end

  // Result of the current request
  always_comb begin
    sched_ok = 1'b0;
    disp_ok  = 1'b0;
    res      = '0;
    unique case (cur.op)
      ejd_pkg::OP_SCHED: begin
        if (!enable) begin
          res.status = ejd_pkg::STAT_DISABLED;
        end else if (pend_count >= ejd_pkg::PEND_CNT_W'(PD)) begin
          res.status = ejd_pkg::STAT_FULL;
        end else begin
          sched_ok   = 1'b1;
          res.status = ejd_pkg::STAT_OK;
          res.job_id = ejd_pkg::JOB_ID_W'(next_id);
        end
      end
      ejd_pkg::OP_DISP: begin
        if (pick_found && slot_ok) begin
          disp_ok      = 1'b1;
          res.status   = ejd_pkg::STAT_OK;
          res.job_id   = ejd_pkg::JOB_ID_W'(pick_id);
          res.out_type = pick_type;
        end else begin
          res.status = ejd_pkg::STAT_NONE;
        end
      end
      ejd_pkg::OP_DONE: begin
        if ((cur.done_id == '0) || !done_hit) begin
          res.status = ejd_pkg::STAT_NOT_ACTIVE;
        end else begin
          res.status = ejd_pkg::STAT_OK;
        end
      end
      ejd_pkg::OP_NOP: begin
        res.status = ejd_pkg::STAT_OK;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = (q_data.op == ejd_pkg::OP_DISP) ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        if (scan_idx == ejd_pkg::ACT_IDX_W'(AD - 1)) begin
          state_next = S_PICK;
        end
      end
      S_PICK:   state_next = S_SLOT;
      S_SLOT:   state_next = S_COMMIT;
      S_COMMIT: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enable     <= 1'b0;
      pend_count <= '0;
      act_valid  <= '0;
      next_id    <= ejd_pkg::ID_WIDTH'(1);
      out_valid  <= 1'b0;
      scan_idx   <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        enable <= cfg_data;
      end
      if (q_take) begin
        scan_idx <= '0;
      end else if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (commit && sched_ok) begin
        pend_count <= pend_count + 1'b1;
        next_id    <= (id_inc == '0) ? ejd_pkg::ID_WIDTH'(1) : id_inc;
      end
      if (commit && disp_ok) begin
        pend_count          <= pend_count - 1'b1;
        act_valid[slot_idx] <= 1'b1;
      end
      if (commit && (cur.op == ejd_pkg::OP_DONE) && (cur.done_id != '0) && done_hit) begin
        act_valid[done_idx] <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_take) begin
      cur     <= q_data;
      blocked <= '0;
    end
    // one active entry per cycle against every pending type
    if (state == S_SCAN) begin
      for (int i = 0; i < PD; i++) begin
        if (act_valid[scan_idx] && (act_types[scan_idx] == pend_types[i].jtype)) begin
          blocked[i] <= 1'b1;
        end
      end
    end
    if (state == S_PICK) begin
      pick_found <= pick_found_c;
      pick_idx   <= pick_idx_c;
      pick_id    <= pend_ids[pick_idx_c];
      pick_type  <= pend_types[pick_idx_c].jtype;
    end
    if (state == S_SLOT) begin
      slot_ok  <= slot_ok_c;
      slot_idx <= slot_idx_c;
    end
    if (commit) begin
      out_rsp <= res;
    end
    // append a scheduled job
    if (commit && sched_ok) begin
      pend_ids[pend_count[ejd_pkg::PEND_IDX_W-1:0]]         <= next_id;
      pend_types[pend_count[ejd_pkg::PEND_IDX_W-1:0]].excl  <= cur.exclusive;
      pend_types[pend_count[ejd_pkg::PEND_IDX_W-1:0]].jtype <= cur.job_type;
    end
    // move the dispatched job to the active table and close the gap
    if (commit && disp_ok) begin
      act_ids[slot_idx]   <= pick_id;
      act_types[slot_idx] <= pick_type;
      for (int k = 0; k < PD - 1; k++) begin
        if (ejd_pkg::PEND_IDX_W'(k) >= pick_idx) begin
          pend_ids[k]   <= pend_ids[k + 1];
          pend_types[k] <= pend_types[k + 1];
        end
      end
    end
  end

endmodule

// ----- rtl/exclusive_type_job_dispatcher_top.sv -----
// ----------------------------------------------------------------------------
// exclusive_type_job_dispatcher_top
// Job dispatcher with type exclusion: request queue in front, execution
// engine with pending list and active table behind it.
// ----------------------------------------------------------------------------
// Schedule, complete and no-op requests pass from the queue straight to the
// commit state; dispatch first walks the active table, one entry per cycle,
// then picks a job and a slot. The engine takes the next request only after
// the last result is committed, which waits while an unread result is held.
// Reset: queues empty, enable low, ID counter at 1, no active jobs; no
// clearing pass, ready right after reset.
module exclusive_type_job_dispatcher_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  ejd_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output ejd_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  logic         q_valid;
  ejd_pkg::op_t q_data;
  logic         q_take;

  // Request intake and classification
  ejd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_take  (q_take)
  );

  // Execution engine
  ejd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_take    (q_take),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/ejd_checker.sv -----
// ----------------------------------------------------------------------------
// ejd_checker
// Port-level checks on the dispatcher results, bound to the top level.
// ----------------------------------------------------------------------------
module ejd_checker (
  input logic          clk,
  input logic          rst,
  input logic          empty,
  input logic          pop,
  input ejd_pkg::rsp_t rsp
);

  // result queue is empty after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rsp)))
    else $error("result changed while waiting");

  // status is a known code
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rsp.status <= ejd_pkg::STAT_NOT_ACTIVE))
    else $error("bad status code");

  // a failed request carries no ID and no type
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (rsp.status != ejd_pkg::STAT_OK)) |-> (rsp.job_id == '0 && rsp.out_type == '0))
    else $error("failed request carries data");

  // a dispatched type always comes with a nonzero ID
  a_disp_id: assert property (@(posedge clk) disable iff (rst)
    (!empty && (rsp.out_type != '0)) |-> (rsp.job_id != '0))
    else $error("dispatch without ID");

endmodule

bind exclusive_type_job_dispatcher_top ejd_checker u_ejd_checker (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .rsp   (rsp)
);

// ----- test/tb_exclusive_type_job_dispatcher_top.sv -----
// ----------------------------------------------------------------------------
// tb_exclusive_type_job_dispatcher_top
// Self-checking bench for the job dispatcher. Directed requests hit the
// disabled, full, blocked-type and unknown-ID corners. Random phases with the
// enable bit toggled follow. Every result is checked against a model of the
// pending list and active table kept in the bench.
// ----------------------------------------------------------------------------
module tb_exclusive_type_job_dispatcher_top;

  localparam int SETTLE_CYCLES = ejd_pkg::ACTIVE_DEPTH + 8;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 105;
  localparam int MAX_PRINTS    = 40;

  // Model of the job tables plus the store of expected results
  class dispatch_checker;
    bit                         enable;
    bit [ejd_pkg::ID_WIDTH-1:0] pend_ids[ejd_pkg::PENDING_DEPTH];
    ejd_pkg::pend_type_t        pend_types[ejd_pkg::PENDING_DEPTH];
    int                         pend_cnt;
    bit [ejd_pkg::ID_WIDTH-1:0] act_ids[ejd_pkg::ACTIVE_DEPTH];
    bit [ejd_pkg::TYPE_W-1:0]   act_types[ejd_pkg::ACTIVE_DEPTH];
    bit                         act_valid[ejd_pkg::ACTIVE_DEPTH];
    bit [ejd_pkg::ID_WIDTH-1:0] next_id;
    ejd_pkg::rsp_t              expected_rsps[$];
    int                         mismatches;

    function new();
      enable     = 1'b0;
      pend_cnt   = 0;
      next_id    = ejd_pkg::ID_WIDTH'(1);
      mismatches = 0;
      foreach (act_valid[i]) act_valid[i] = 1'b0;
    endfunction

    // Lowest active entry holding this ID, -1 if none
    function int find_active(bit [ejd_pkg::ID_WIDTH-1:0] id);
      foreach (act_valid[i])
        if (act_valid[i] && act_ids[i] == id) return i;
      return -1;
    endfunction

    function bit [ejd_pkg::ID_WIDTH-1:0] pick_active_id();
      bit [ejd_pkg::ID_WIDTH-1:0] ids[$];
      foreach (act_valid[i])
        if (act_valid[i]) ids = {ids, act_ids[i]};
      if (ids.size() == 0) return '0;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // Apply one accepted request to the model; returns and stores its result
    function ejd_pkg::rsp_t note_request(ejd_pkg::req_t r);
      ejd_pkg::rsp_t e;
      int            slot;
      bit            busy;
      bit            hit;
      e = '0;
      case (r.cmd)
        ejd_pkg::CMD_SCHED: begin
          if (!enable) begin
            e.status = ejd_pkg::STAT_DISABLED;
          end else if (pend_cnt >= ejd_pkg::PENDING_DEPTH) begin
            e.status = ejd_pkg::STAT_FULL;
          end else begin
            e.status = ejd_pkg::STAT_OK;
            e.job_id = next_id;
            pend_ids[pend_cnt]         = next_id;
            pend_types[pend_cnt].excl  = r.exclusive;
            pend_types[pend_cnt].jtype = r.job_type;
            pend_cnt++;
            next_id++;
            if (next_id == 0) next_id = ejd_pkg::ID_WIDTH'(1);  // counter skips zero
          end
        end
        ejd_pkg::CMD_DISP: begin
          e.status = ejd_pkg::STAT_NONE;
          hit = 1'b0;
          // oldest eligible job wins; stop at it even if no entry is free
          for (int i = 0; i < pend_cnt && !hit; i++) begin
            busy = 1'b0;
            if (pend_types[i].excl)
              foreach (act_valid[j])
                if (act_valid[j] && act_types[j] == pend_types[i].jtype) busy = 1'b1;
            if (!busy) begin
              hit  = 1'b1;
              slot = find_active(pend_ids[i]);
              if (slot < 0)
                foreach (act_valid[j])
                  if (!act_valid[j] && slot < 0) slot = j;
              if (slot >= 0) begin
                act_ids[slot]   = pend_ids[i];
                act_types[slot] = pend_types[i].jtype;
                act_valid[slot] = 1'b1;
                e.status   = ejd_pkg::STAT_OK;
                e.job_id   = pend_ids[i];
                e.out_type = pend_types[i].jtype;
                for (int k = i; k + 1 < pend_cnt; k++) begin
                  pend_ids[k]   = pend_ids[k + 1];
                  pend_types[k] = pend_types[k + 1];
                end
                pend_cnt--;
              end
            end
          end
        end
        ejd_pkg::CMD_DONE: begin
          slot = find_active(r.done_id);
          if (r.done_id == 0 || slot < 0) e.status = ejd_pkg::STAT_NOT_ACTIVE;
          else act_valid[slot] = 1'b0;
        end
        default: e.status = ejd_pkg::STAT_OK;
      endcase
      expected_rsps = {expected_rsps, e};
      return e;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(ejd_pkg::rsp_t got);
      ejd_pkg::rsp_t want;
      if (expected_rsps.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: status %0d id %0d",
                                  got.status, got.job_id));
        return;
      end
      want = expected_rsps.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.job_id !== want.job_id)
        report_mismatch($sformatf("job_id %0d, want %0d", got.job_id, want.job_id));
      if (got.out_type !== want.out_type)
        report_mismatch($sformatf("out_type %h, want %h", got.out_type, want.out_type));
    endtask
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          push      = 1'b0;
  logic          full;
  ejd_pkg::req_t req       = '0;
  logic          empty;
  logic          pop       = 1'b0;
  ejd_pkg::rsp_t rsp;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_data  = 1'b0;

  dispatch_checker chk = new();

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  exclusive_type_job_dispatcher_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Result side: pop follows a stall pattern whose mode is redrawn when its countdown runs out
  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_mode)
        0:       pop = 1'b1;
        1:       pop = ($urandom_range(0, 3) != 0);
        2:       pop = ($urandom_range(0, 1) == 1);
        default: pop = (stall_left % 9 == 0);
      endcase
    end
  end

  always @(posedge clk)
    if (!rst && pop && !empty) chk.check_result(rsp);

  initial begin
    #40000000;
    $display("[exclusive_type_job_dispatcher_top] ERROR");
    $finish;
  end

  function automatic ejd_pkg::req_t mk_req(logic [ejd_pkg::CMD_W-1:0] cmd,
                                           logic [ejd_pkg::TYPE_W-1:0] jt,
                                           logic ex,
                                           logic [ejd_pkg::DONE_W-1:0] did);
    ejd_pkg::req_t r;
    r.cmd       = cmd;
    r.job_type  = jt;
    r.exclusive = ex;
    r.done_id   = did;
    return r;
  endfunction

  // Random request; mode 0 fills the tables, 1 is balanced, 2 empties them
  function automatic ejd_pkg::req_t make_req(int mode);
    ejd_pkg::req_t r;
    int            roll;
    r.done_id   = ejd_pkg::DONE_W'($urandom);
    r.exclusive = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 7);
    // small pool of types so that exclusion blocks often
    if (roll == 0)      r.job_type = $urandom;
    else if (roll == 1) r.job_type = '0;
    else if (roll == 2) r.job_type = '1;
    else                r.job_type = 32'hC0DE_0000 + roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0:       r.cmd = roll < 45 ? ejd_pkg::CMD_SCHED :
                       roll < 80 ? ejd_pkg::CMD_DISP  :
                       roll < 93 ? ejd_pkg::CMD_DONE  : ejd_pkg::CMD_NOP;
      1:       r.cmd = roll < 30 ? ejd_pkg::CMD_SCHED :
                       roll < 65 ? ejd_pkg::CMD_DISP  :
                       roll < 95 ? ejd_pkg::CMD_DONE  : ejd_pkg::CMD_NOP;
      default: r.cmd = roll < 15 ? ejd_pkg::CMD_SCHED :
                       roll < 55 ? ejd_pkg::CMD_DISP  :
                       roll < 95 ? ejd_pkg::CMD_DONE  : ejd_pkg::CMD_NOP;
    endcase
    if (r.cmd == ejd_pkg::CMD_DONE) begin
      roll = $urandom_range(0, 9);
      if (roll < 8)       r.done_id = chk.pick_active_id();
      else if (roll == 8) r.done_id = '0;
    end
    return r;
  endfunction

  // One request through the push/full handshake, then maybe a sender gap
  task automatic send_req(input ejd_pkg::req_t r, output ejd_pkg::rsp_t want);
    @(negedge clk);
    push = 1'b1;
    req  = r;
    do @(posedge clk); while (full !== 1'b0);
    want = chk.note_request(r);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Hold off until every expected result is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (chk.expected_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    chk.enable = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    ejd_pkg::rsp_t              want;
    logic [ejd_pkg::TYPE_W-1:0] jt;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Disabled: schedule refused, dispatch still runs, unknown IDs, no-op
    send_req(mk_req(ejd_pkg::CMD_SCHED, '1, 1'b1, '0), want);
    send_req(mk_req(ejd_pkg::CMD_DISP, '0, 1'b0, '1), want);
    send_req(mk_req(ejd_pkg::CMD_DONE, '1, 1'b1, '0), want);
    send_req(mk_req(ejd_pkg::CMD_DONE, '0, 1'b0, '1), want);
    send_req(mk_req(ejd_pkg::CMD_NOP, '1, 1'b1, '1), want);

    // Fill the pending list, then overflow it
    write_enable(1'b1);
    for (int k = 0; k < ejd_pkg::PENDING_DEPTH; k++) begin
      if (k < 2)       jt = 32'h5A5A_0001;
      else if (k == 2) jt = '0;
      else if (k == 3) jt = '1;
      else             jt = 32'h0000_1000 + k;
      send_req(mk_req(ejd_pkg::CMD_SCHED, jt, k != 2, ejd_pkg::DONE_W'($urandom)), want);
    end
    send_req(mk_req(ejd_pkg::CMD_SCHED, 32'h0000_7777, 1'b0, '1), want);

    // ID 1 goes active; ID 2 shares its exclusive type and is skipped for ID 3
    send_req(mk_req(ejd_pkg::CMD_DISP, '0, 1'b0, '0), want);
    send_req(mk_req(ejd_pkg::CMD_DISP, '1, 1'b1, '0), want);
    send_req(mk_req(ejd_pkg::CMD_DONE, '0, 1'b0, 16'd3), want);

    // Random phases; enable drops every fourth phase
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_enable(p % 4 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p % 2 == 1 && n == PHASE_ITEMS / 2) drain();
        send_req(make_req(p % 3), want);
      end
    end
    drain();

    if (chk.mismatches == 0 && chk.expected_rsps.size() == 0) begin
      $display("[exclusive_type_job_dispatcher_top] OK");
    end else begin
      $display("[exclusive_type_job_dispatcher_top] ERROR");
    end
    $finish;
  end

endmodule
